// ===== hdl/i2c_register_master_defines.svh =====
// ---------------------------------------------------------------------------
// I2C register master assertion macros
// Clocked assertion helpers for the RTL of the block, used by the engine.
// ---------------------------------------------------------------------------
`ifndef I2C_REGISTER_MASTER_DEFINES_SVH
`define I2C_REGISTER_MASTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define IRM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define IRM_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define IRM_ASSERT(lbl, clk, rst, prop, msg)
`define IRM_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== hdl/irm_pkg.sv =====
// ---------------------------------------------------------------------------
// I2C register master package
// Shared types and constants of the I2C register master.
// ---------------------------------------------------------------------------
`default_nettype none

package irm_pkg;

  localparam int TIMER_BITS_DEF   = 16;
  localparam int IN_WIDTH         = 32;
  localparam int OUT_WIDTH        = 24;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd250;

  // Transaction modes.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_RD1   = 2'd1;
  localparam logic [1:0] MODE_RD2   = 2'd2;
  localparam logic [1:0] MODE_BAD   = 2'd3;

  // One tick word after unpacking.
  typedef struct packed {
    logic       req_valid;
    logic [1:0] mode;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       wr_last;
    logic       sda_in;
    logic       scl_in;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [15:0] read_data;
    logic        nack_seen;
    logic        done_res;
    logic        data_take;
    logic        busy_res;
    logic        sda_pull_low;
    logic        scl_pull_low;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/irm_front.sv =====
// ---------------------------------------------------------------------------
// I2C register master front end
// Accepts tick words, unpacks their fields and queues them for the engine.
// ---------------------------------------------------------------------------
`default_nettype none

module irm_front import irm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [IN_WIDTH-1:0] s_tdata,
  input  wire logic                s_tlast,
  output logic                     q_valid,
  output item_t                    q_item,
  input  wire logic                q_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      in_item;

  // Unpack the incoming word.
  always_comb begin
    in_item.req_valid = s_tdata[0];
    in_item.mode      = s_tdata[2:1];
    in_item.dev_addr  = s_tdata[9:3];
    in_item.reg_addr  = s_tdata[17:10];
    in_item.wr_data   = s_tdata[25:18];
    in_item.wr_last   = s_tlast;
    in_item.sda_in    = s_tdata[26];
    in_item.scl_in    = s_tdata[27];
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  // Two-entry queue between front end and engine.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/irm_engine.sv =====
// ---------------------------------------------------------------------------
// I2C register master engine
// Runs the bus sequencer one tick per queued word and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "i2c_register_master_defines.svh"

module irm_engine import irm_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 q_valid,
  input  item_t                     q_item,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [OUT_WIDTH-1:0]      m_tdata
);

  localparam int CW = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;

  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_RS0  = 5'd1;
  localparam logic [4:0] PH_S1   = 5'd2;
  localparam logic [4:0] PH_S2   = 5'd3;
  localparam logic [4:0] PH_S3   = 5'd4;
  localparam logic [4:0] PH_RXL  = 5'd5;
  localparam logic [4:0] PH_RXH  = 5'd6;
  localparam logic [4:0] PH_MAL  = 5'd7;
  localparam logic [4:0] PH_TXL  = 5'd8;
  localparam logic [4:0] PH_TXH  = 5'd12;
  localparam logic [4:0] PH_AKL  = 5'd16;
  localparam logic [4:0] PH_AKH  = 5'd20;
  localparam logic [4:0] PH_MAH  = 5'd24;
  localparam logic [4:0] PH_P0   = 5'd25;
  localparam logic [4:0] PH_P1   = 5'd26;
  localparam logic [4:0] PH_P2   = 5'd27;
  localparam logic [4:0] PH_END  = 5'd28;

  localparam logic [1:0] K_ADDR_W = 2'd0;
  localparam logic [1:0] K_REG    = 2'd1;
  localparam logic [1:0] K_DATA   = 2'd2;
  localparam logic [1:0] K_ADDR_R = 2'd3;

  localparam int PAD_BITS = OUT_WIDTH - $bits(result_t);

  logic [15:0]           half_period;
  logic [4:0]            phase, phase_next;
  logic [TIMER_BITS-1:0] tick_count, tick_count_next;
  logic [3:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [15:0]           read_accum, read_accum_next;
  logic [1:0]            held_mode, held_mode_next;
  logic [6:0]            held_dev, held_dev_next;
  logic [7:0]            held_reg, held_reg_next;
  logic                  byte_is_last, byte_is_last_next;
  logic                  nack_flag, nack_flag_next;
  logic                  step_end;
  logic [1:0]            k;
  logic [3:0]            bit_inc;
  logic [CW-1:0]         tick_inc;
  result_t               res;
  result_t               out_word;

  assign cfg_ready = 1'b1;
  assign q_pop     = q_valid && (!m_tvalid || m_tready);
  assign m_tdata   = {{PAD_BITS{1'b0}}, out_word};
  assign k         = phase[1:0];
  assign bit_inc   = bit_index + 4'd1;
  assign tick_inc  = CW'(tick_count) + CW'(1);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RST;
    end else if (cfg_valid) begin
      half_period <= cfg_data;
    end
  end

  // One bus tick: pin drive, step timer and phase sequencing.
  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    read_accum_next   = read_accum;
    held_mode_next    = held_mode;
    held_dev_next     = held_dev;
    held_reg_next     = held_reg;
    byte_is_last_next = byte_is_last;
    nack_flag_next    = nack_flag;
    step_end          = 1'b0;
    res               = '0;

    // Pin drive follows the current phase.
    if (phase >= PH_TXL && phase < PH_AKL) begin
      res.scl_pull_low = (phase < PH_TXH);
      res.sda_pull_low = ~shift_byte[7];
    end else if (phase >= PH_AKL && phase < PH_MAH) begin
      res.scl_pull_low = (phase < PH_AKH);
    end else begin
      unique case (phase)
        PH_RS0: res.scl_pull_low = 1'b1;
        PH_S2:  res.sda_pull_low = 1'b1;
        PH_S3: begin
          res.scl_pull_low = 1'b1;
          res.sda_pull_low = 1'b1;
        end
        PH_RXL: res.scl_pull_low = 1'b1;
        PH_MAL: begin
          res.scl_pull_low = 1'b1;
          res.sda_pull_low = ~byte_is_last;
        end
        PH_MAH: res.sda_pull_low = ~byte_is_last;
        PH_P0: begin
          res.scl_pull_low = 1'b1;
          res.sda_pull_low = 1'b1;
        end
        PH_P1:  res.sda_pull_low = 1'b1;
        default: ;
      endcase
    end
    res.busy_res = (phase != PH_IDLE);

    // Start a transaction, or run the step timer while SCL is not stretched.
    if (phase == PH_IDLE) begin
      if (q_item.req_valid && q_item.mode != MODE_BAD) begin
        held_mode_next    = q_item.mode;
        held_dev_next     = q_item.dev_addr;
        held_reg_next     = q_item.reg_addr;
        nack_flag_next    = 1'b0;
        read_accum_next   = '0;
        shift_byte_next   = {q_item.dev_addr, 1'b0};
        bit_index_next    = '0;
        byte_is_last_next = 1'b0;
        tick_count_next   = '0;
        phase_next        = PH_S1;
      end
    end else if (res.scl_pull_low || q_item.scl_in) begin
      if (tick_inc >= CW'(half_period) || (&tick_count)) begin
        step_end = 1'b1;
      end else begin
        tick_count_next = tick_count + TIMER_BITS'(1);
      end
    end

    // Phase change at the end of a step.
    if (step_end) begin
      tick_count_next = '0;
      if (phase >= PH_TXL && phase < PH_TXH) begin
        phase_next = PH_TXH + {3'b000, k};
      end else if (phase >= PH_TXH && phase < PH_AKL) begin
        shift_byte_next = {shift_byte[6:0], 1'b0};
        bit_index_next  = bit_inc;
        phase_next      = (bit_inc >= 4'd8) ? PH_AKL + {3'b000, k} : PH_TXL + {3'b000, k};
      end else if (phase >= PH_AKL && phase < PH_AKH) begin
        phase_next = PH_AKH + {3'b000, k};
      end else if (phase >= PH_AKH && phase < PH_MAH) begin
        if (q_item.sda_in) begin
          nack_flag_next = 1'b1;
          phase_next     = PH_P0;
        end else begin
          unique case (k)
            K_ADDR_W: begin
              shift_byte_next = held_reg;
              bit_index_next  = '0;
              phase_next      = PH_TXL + {3'b000, K_REG};
            end
            K_REG: begin
              if (held_mode == MODE_WRITE) begin
                res.data_take     = 1'b1;
                shift_byte_next   = q_item.wr_data;
                byte_is_last_next = q_item.wr_last;
                bit_index_next    = '0;
                phase_next        = PH_TXL + {3'b000, K_DATA};
              end else begin
                shift_byte_next = {held_dev, 1'b1};
                phase_next      = PH_RS0;
              end
            end
            K_DATA: begin
              if (byte_is_last) begin
                phase_next = PH_P0;
              end else begin
                res.data_take     = 1'b1;
                shift_byte_next   = q_item.wr_data;
                byte_is_last_next = q_item.wr_last;
                bit_index_next    = '0;
                phase_next        = PH_TXL + {3'b000, K_DATA};
              end
            end
            K_ADDR_R: begin
              bit_index_next    = '0;
              byte_is_last_next = (held_mode != MODE_RD2);
              phase_next        = PH_RXL;
            end
            default: ;
          endcase
        end
      end else begin
        unique case (phase)
          PH_RS0: phase_next = PH_S1;
          PH_S1:  phase_next = PH_S2;
          PH_S2:  phase_next = PH_S3;
          PH_S3: begin
            bit_index_next = '0;
            phase_next     = shift_byte[0] ? PH_TXL + {3'b000, K_ADDR_R}
                                           : PH_TXL + {3'b000, K_ADDR_W};
          end
          PH_RXL: phase_next = PH_RXH;
          PH_RXH: begin
            read_accum_next = {read_accum[14:0], q_item.sda_in};
            bit_index_next  = bit_inc;
            phase_next      = (bit_inc >= 4'd8) ? PH_MAL : PH_RXL;
          end
          PH_MAL: phase_next = PH_MAH;
          PH_MAH: begin
            if (byte_is_last) begin
              phase_next = PH_P0;
            end else begin
              byte_is_last_next = 1'b1;
              bit_index_next    = '0;
              phase_next        = PH_RXL;
            end
          end
          PH_P0: phase_next = PH_P1;
          PH_P1: phase_next = PH_P2;
          PH_P2: begin
            res.done_res = 1'b1;
            phase_next   = PH_IDLE;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end

    if (res.done_res) begin
      res.nack_seen = nack_flag;
      res.read_data = read_accum;
    end
  end

  // Sequencer state advances once per consumed tick word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      bit_index    <= '0;
      shift_byte   <= '0;
      read_accum   <= '0;
      held_mode    <= '0;
      held_dev     <= '0;
      held_reg     <= '0;
      byte_is_last <= 1'b0;
      nack_flag    <= 1'b0;
    end else if (q_pop) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_index    <= bit_index_next;
      shift_byte   <= shift_byte_next;
      read_accum   <= read_accum_next;
      held_mode    <= held_mode_next;
      held_dev     <= held_dev_next;
      held_reg     <= held_reg_next;
      byte_is_last <= byte_is_last_next;
      nack_flag    <= nack_flag_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_word <= res;
    end
  end

  `IRM_ASSERT(a_done_busy, clk, rst, (m_tvalid && out_word.done_res) |-> out_word.busy_res, "done without busy")
  `IRM_ASSERT_NEVER(a_take_done, clk, rst, m_tvalid && out_word.done_res && out_word.data_take, "take on done")
  `IRM_ASSERT(a_phase_range, clk, rst, phase < PH_END, "phase out of range")

endmodule

`default_nettype wire

// ===== hdl/i2c_register_master.sv =====
// ---------------------------------------------------------------------------
// I2C register master
// Open-drain I2C master running register writes and one- or two-byte reads.
// ---------------------------------------------------------------------------
//  channel  dir  width  contents
//  s_*      in   32     one bus tick: request fields and sampled pins
//  m_*      out  24     pin drive, status and read data for that tick
//  cfg_*    in   16     half_period register
//
// Each tick word yields exactly one result word; the engine takes one word
// per cycle while the output does not stall, so the block then sustains
// one item per clock. Words pass through the queue and the output register.
// Reset clears the queue, the sequencer and sets half_period to 250.
// A stalled output holds its word while the queue accepts input until its
// two entries are full.
`default_nettype none

module i2c_register_master import irm_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // req_valid, mode[2], dev_addr[7], reg_addr[8], wr_data[8], sda_in, scl_in
  input  wire logic [IN_WIDTH-1:0]  s_tdata,
  input  wire logic                 s_tlast,   // wr_last
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // scl_pull_low, sda_pull_low, busy_res, data_take, done_res, nack_seen,
  // read_data[16]
  output logic [OUT_WIDTH-1:0]      m_tdata,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [15:0]          cfg_data
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Tick word intake and queue.
  irm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Bus sequencer and result register.
  irm_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

// ===== sim/irm_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C register master checker
// Watches the tick, result and configuration channels, runs its own model of
// the bus sequencer on every accepted tick word and compares each result word
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module irm_checker import irm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output logic             engine_idle
);

  // Sequencer phase codes.
  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_RS0  = 5'd1;
  localparam logic [4:0] PH_S1   = 5'd2;
  localparam logic [4:0] PH_S2   = 5'd3;
  localparam logic [4:0] PH_S3   = 5'd4;
  localparam logic [4:0] PH_RXL  = 5'd5;
  localparam logic [4:0] PH_RXH  = 5'd6;
  localparam logic [4:0] PH_MAL  = 5'd7;
  localparam logic [4:0] PH_TXL  = 5'd8;
  localparam logic [4:0] PH_TXH  = 5'd12;
  localparam logic [4:0] PH_AKL  = 5'd16;
  localparam logic [4:0] PH_AKH  = 5'd20;
  localparam logic [4:0] PH_MAH  = 5'd24;
  localparam logic [4:0] PH_P0   = 5'd25;
  localparam logic [4:0] PH_P1   = 5'd26;
  localparam logic [4:0] PH_P2   = 5'd27;

  // Byte kinds, kept in the low two bits of the transmit and ACK phases.
  localparam logic [1:0] K_ADDR_W = 2'd0;
  localparam logic [1:0] K_REG    = 2'd1;
  localparam logic [1:0] K_DATA   = 2'd2;
  localparam logic [1:0] K_ADDR_R = 2'd3;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // Model state.
  logic [15:0] half_period;
  logic [4:0]  phase;
  logic [15:0] tick_count;
  logic [3:0]  bit_index;
  logic [7:0]  shift_byte;
  logic [15:0] read_accum;
  logic [1:0]  held_mode;
  logic [6:0]  held_dev;
  logic [7:0]  held_reg;
  logic        byte_is_last;
  logic        nack_flag;

  result_t expected_words[$];
  int      mismatch_count;

  assign pending     = expected_words.size();
  assign fail_count  = mismatch_count;
  assign engine_idle = (phase == PH_IDLE);

  // Loads a write data byte into the transmitter.
  task automatic load_data_byte(input item_t it, inout result_t r);
    r.data_take  = 1'b1;
    shift_byte   = it.wr_data;
    byte_is_last = it.wr_last;
    bit_index    = 4'd0;
    phase        = PH_TXL + K_DATA;
  endtask

  // Advances the model by one tick and returns the word it produces.
  task automatic bus_tick(input item_t it, output result_t r);
    logic       step_end;
    logic [1:0] kind;
    r = '0;
    step_end = 1'b0;
    // Pin drive is decided by the phase at the start of the tick.
    if (phase >= PH_TXL && phase < PH_AKL) begin
      r.scl_pull_low = (phase < PH_TXH);
      r.sda_pull_low = !shift_byte[7];
    end else if (phase >= PH_AKL && phase < PH_MAH) begin
      r.scl_pull_low = (phase < PH_AKH);
    end else begin
      case (phase)
        PH_RS0: r.scl_pull_low = 1'b1;
        PH_S2:  r.sda_pull_low = 1'b1;
        PH_S3: begin
          r.scl_pull_low = 1'b1;
          r.sda_pull_low = 1'b1;
        end
        PH_RXL: r.scl_pull_low = 1'b1;
        PH_MAL: begin
          r.scl_pull_low = 1'b1;
          r.sda_pull_low = !byte_is_last;
        end
        PH_MAH: r.sda_pull_low = !byte_is_last;
        PH_P0: begin
          r.scl_pull_low = 1'b1;
          r.sda_pull_low = 1'b1;
        end
        PH_P1: r.sda_pull_low = 1'b1;
        default: ;
      endcase
    end
    r.busy_res = (phase != PH_IDLE);

    // Request acceptance when idle, otherwise the step timer. A released SCL
    // held low by the slave freezes the timer.
    if (phase == PH_IDLE) begin
      if (it.req_valid && it.mode != MODE_BAD) begin
        held_mode    = it.mode;
        held_dev     = it.dev_addr;
        held_reg     = it.reg_addr;
        nack_flag    = 1'b0;
        read_accum   = '0;
        shift_byte   = {it.dev_addr, 1'b0};
        bit_index    = '0;
        byte_is_last = 1'b0;
        tick_count   = '0;
        phase        = PH_S1;
      end
    end else if (!(!r.scl_pull_low && !it.scl_in)) begin
      if ({1'b0, tick_count} + 17'd1 >= {1'b0, half_period} || tick_count == TICK_MAX)
        step_end = 1'b1;
      else
        tick_count = tick_count + 16'd1;
    end

    if (step_end) begin
      kind = phase[1:0];
      tick_count = '0;
      if (phase >= PH_TXL && phase < PH_TXH) begin
        phase = PH_TXH + kind;
      end else if (phase >= PH_TXH && phase < PH_AKL) begin
        shift_byte = shift_byte << 1;
        bit_index  = bit_index + 4'd1;
        phase      = (bit_index >= 4'd8) ? PH_AKL + kind : PH_TXL + kind;
      end else if (phase >= PH_AKL && phase < PH_AKH) begin
        phase = PH_AKH + kind;
      end else if (phase >= PH_AKH && phase < PH_MAH) begin
        // ACK slot: high SDA is a NACK and ends the transaction.
        if (it.sda_in) begin
          nack_flag = 1'b1;
          phase     = PH_P0;
        end else if (kind == K_ADDR_W) begin
          shift_byte = held_reg;
          bit_index  = '0;
          phase      = PH_TXL + K_REG;
        end else if (kind == K_REG) begin
          if (held_mode == MODE_WRITE) begin
            load_data_byte(it, r);
          end else begin
            shift_byte = {held_dev, 1'b1};
            phase      = PH_RS0;
          end
        end else if (kind == K_DATA) begin
          if (byte_is_last) phase = PH_P0;
          else load_data_byte(it, r);
        end else begin
          bit_index    = '0;
          byte_is_last = (held_mode != MODE_RD2);
          phase        = PH_RXL;
        end
      end else begin
        case (phase)
          PH_RS0: phase = PH_S1;
          PH_S1:  phase = PH_S2;
          PH_S2:  phase = PH_S3;
          PH_S3: begin
            bit_index = '0;
            phase     = PH_TXL + (shift_byte[0] ? K_ADDR_R : K_ADDR_W);
          end
          PH_RXL: phase = PH_RXH;
          PH_RXH: begin
            read_accum = {read_accum[14:0], it.sda_in};
            bit_index  = bit_index + 4'd1;
            phase      = (bit_index >= 4'd8) ? PH_MAL : PH_RXL;
          end
          PH_MAL: phase = PH_MAH;
          PH_MAH: begin
            if (byte_is_last) begin
              phase = PH_P0;
            end else begin
              byte_is_last = 1'b1;
              bit_index    = '0;
              phase        = PH_RXL;
            end
          end
          PH_P0: phase = PH_P1;
          PH_P1: phase = PH_P2;
          PH_P2: begin
            r.done_res = 1'b1;
            phase      = PH_IDLE;
          end
          default: phase = PH_IDLE;
        endcase
      end
    end

    if (r.done_res) begin
      r.nack_seen = nack_flag;
      r.read_data = read_accum;
    end
  endtask

  // Channel monitor: predicts on accepted ticks, compares accepted results.
  always @(posedge clk) begin
    item_t   it;
    result_t want;
    result_t got;
    if (rst) begin
      half_period  = HALF_PERIOD_RST;
      phase        = PH_IDLE;
      tick_count   = '0;
      bit_index    = '0;
      shift_byte   = '0;
      read_accum   = '0;
      held_mode    = '0;
      held_dev     = '0;
      held_reg     = '0;
      byte_is_last = 1'b0;
      nack_flag    = 1'b0;
      expected_words.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) half_period = cfg_data;
      if (s_tvalid && s_tready) begin
        it.req_valid = s_tdata[0];
        it.mode      = s_tdata[2:1];
        it.dev_addr  = s_tdata[9:3];
        it.reg_addr  = s_tdata[17:10];
        it.wr_data   = s_tdata[25:18];
        it.sda_in    = s_tdata[26];
        it.scl_in    = s_tdata[27];
        it.wr_last   = s_tlast;
        bus_tick(it, want);
        expected_words.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.scl_pull_low = m_tdata[0];
        got.sda_pull_low = m_tdata[1];
        got.busy_res     = m_tdata[2];
        got.data_take    = m_tdata[3];
        got.done_res     = m_tdata[4];
        got.nack_seen    = m_tdata[5];
        got.read_data    = m_tdata[21:6];
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result word %h with no prediction waiting", m_tdata);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: scl/sda/busy/take/done/nack/data expected %b %b %b %b %b %b %h, got %b %b %b %b %b %b %h",
                want.scl_pull_low, want.sda_pull_low, want.busy_res, want.data_take,
                want.done_res, want.nack_seen, want.read_data,
                got.scl_pull_low, got.sda_pull_low, got.busy_res, got.data_take,
                got.done_res, got.nack_seen, got.read_data);
          end
        end
      end
    end
  end

endmodule

// ===== sim/tb_i2c_register_master.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C register master testbench
// Drives bus ticks with requests, slave ACK and stretch behavior under random
// gaps and output stalls, across several half period settings.
// ---------------------------------------------------------------------------
module tb_i2c_register_master import irm_pkg::*;;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // req_valid, mode[2], dev_addr[7], reg_addr[8],
                                // wr_data[8], sda_in, scl_in, zero fill
  logic        s_tlast = 1'b0;  // wr_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // scl_pull_low, sda_pull_low, busy_res, data_take,
                                // done_res, nack_seen, read_data[16], zero fill
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int   fail_count;
  int   pending;
  logic engine_idle;
  bit   no_gaps;
  bit   no_stalls;
  int   sda_low_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_register_master u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  irm_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .engine_idle(engine_idle)
  );

  // Sends one tick word after a random gap; called at a falling edge.
  task automatic send_tick(input logic req, input logic [1:0] mode, input logic [6:0] dev,
                           input logic [7:0] reg_idx, input logic [7:0] wdata,
                           input logic wlast, input logic sda, input logic scl);
    int  gap;
    bit  ready_seen;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, scl, sda, wdata, reg_idx, dev, mode, req};
    s_tlast  <= wlast;
    do begin
      #1 ready_seen = s_tready;
      @(posedge clk);
      @(negedge clk);
    end while (!ready_seen);
  endtask

  // Random tick: the slave ACKs most of the time and sometimes stretches SCL.
  task automatic random_tick();
    logic       req;
    logic [1:0] mode;
    req  = ($urandom_range(0, 99) < 15);
    mode = ($urandom_range(0, 19) == 0) ? MODE_BAD : 2'($urandom_range(0, 2));
    if (req && engine_idle) sda_low_pct = ($urandom_range(0, 3) == 0) ? 50 : 96;
    send_tick(req, mode, 7'($urandom), 8'($urandom), 8'($urandom),
              ($urandom_range(0, 99) < 35), ($urandom_range(0, 99) >= sda_low_pct),
              ($urandom_range(0, 99) >= 8));
  endtask

  // Issues one request and then ticks until the transaction has ended.
  task automatic directed_txn(input logic [1:0] mode, input logic [6:0] dev,
                              input logic [7:0] reg_idx, input logic slave_nacks);
    send_tick(1'b1, mode, dev, reg_idx, 8'hFF, 1'b0, 1'b1, 1'b1);
    while (!engine_idle)
      send_tick(1'b0, MODE_WRITE, '0, '0, 8'($urandom), ($urandom_range(0, 2) == 0),
                slave_nacks, 1'b1);
  endtask

  // Writes half_period once everything in flight has drained; called at a
  // falling edge.
  task automatic set_half_period(input logic [15:0] value);
    bit ready_seen;
    while (!engine_idle) random_tick();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      #1 ready_seen = cfg_ready;
      @(posedge clk);
      @(negedge clk);
    end while (!ready_seen);
    cfg_valid <= 1'b0;
  endtask

  // Random stalls on the result side, with stall-free stretches.
  initial begin
    int  stall;
    bit  valid_seen;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_stalls ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do begin
        #1 valid_seen = m_tvalid;
        @(posedge clk);
        @(negedge clk);
      end while (!valid_seen);
    end
  end

  // Stimulus and verdict.
  initial begin
    int phase_ticks;
    no_gaps     = 1'b0;
    no_stalls   = 1'b0;
    sda_low_pct = 96;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A few idle ticks at the reset period, including a rejected mode.
    repeat (4) send_tick(1'b0, MODE_WRITE, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, MODE_BAD, 7'h7F, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);

    // Directed transactions at the shortest bus step.
    set_half_period(16'd1);
    directed_txn(MODE_WRITE, 7'h7F, 8'hFF, 1'b0);
    directed_txn(MODE_WRITE, 7'h00, 8'h00, 1'b0);
    directed_txn(MODE_RD1, 7'h55, 8'hAA, 1'b0);
    directed_txn(MODE_RD2, 7'h2A, 8'h55, 1'b0);
    directed_txn(MODE_RD2, 7'h7F, 8'h00, 1'b1);
    directed_txn(MODE_WRITE, 7'h01, 8'h80, 1'b1);
    send_tick(1'b1, MODE_BAD, 7'h12, 8'h34, 8'h56, 1'b0, 1'b0, 1'b1);

    // Random phases at several periods; the longest one cannot finish.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin set_half_period(16'd1); phase_ticks = 550; end
        1: begin set_half_period(16'd2); phase_ticks = 250; end
        2: begin set_half_period(16'd3); phase_ticks = 200; end
        default: begin set_half_period(16'hFFFF); phase_ticks = 30; end
      endcase
      for (int i = 0; i < phase_ticks; i++) begin
        if (i % 100 == 0) begin
          no_gaps   = ($urandom_range(0, 3) == 0);
          no_stalls = ($urandom_range(0, 3) == 0);
        end
        random_tick();
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
